FILE: rtl/core/irfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irfe_pkg;

  // Encoding modes
  localparam logic [1:0] MODE_PULSE_POSITION = 2'd0;
  localparam logic [1:0] MODE_PULSE_LENGTH   = 2'd1;
  localparam logic [1:0] MODE_BI_PHASE       = 2'd2;
  localparam logic [1:0] MODE_UNUSED         = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_ON_TIME  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_OFF_TIME = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TIME          = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TIME         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIME          = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POSTAMBLE_TIME    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS        = 4'd7;

  // Segment slots of one byte: preamble pair, eight bit pairs, postamble and gap
  localparam logic [4:0] SEG_PRE_ON   = 5'd0;
  localparam logic [4:0] SEG_BIT_BASE = 5'd2;
  localparam logic [4:0] SEG_POST     = 5'd18;
  localparam logic [4:0] SEG_GAP      = 5'd19;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pre_on;
    logic [15:0] pre_off;
    logic [15:0] one_time;
    logic [15:0] zero_time;
    logic [15:0] gap_time;
    logic [15:0] post_time;
    logic [7:0]  frame_bits;
  } cfg_t;

  // What one byte has to send
  typedef struct packed {
    logic       emit;
    logic [1:0] mode;
    logic [7:0] data;
    logic       pre;
    logic [3:0] nbits;
    logic       post;
  } plan_t;

endpackage

`default_nettype wire

FILE: rtl/core/ir_remote_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Infrared remote frame encoder. Each command byte becomes a run of carrier
// segments (carrier on/off plus a duration in microseconds), one segment per
// clock on the out_ channel while out_stall is low: two preamble segments
// when the byte opens a frame, two per data bit (LSB first, up to eight,
// until frame_bits runs out), and postamble plus gap when the frame closes.
// The next byte is taken in the cycle the last segment of the current one
// moves to the output register. Bytes written while encoding_mode is 3 are
// taken and dropped. The user must write registers only while no segments
// are pending; the block itself does not enforce this.
module ir_remote_frame_encoder_unit
  import irfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_carrier_on,
  output logic [15:0]                out_duration,
  output logic                       out_last_of_run,
  output logic                       out_frame_end
);

  cfg_t  cfg;
  plan_t plan;
  logic  seq_ready;
  logic  in_fire;

  assign in_stall = !seq_ready;
  assign in_fire  = in_valid && seq_ready;

  irfe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irfe_frame_planner u_plan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .data_byte (in_data_byte),
    .take      (in_fire),
    .plan      (plan)
  );

  irfe_seg_sequencer u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .plan            (plan),
    .in_fire         (in_fire),
    .ready           (seq_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_carrier_on  (out_carrier_on),
    .out_duration    (out_duration),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule

`default_nettype wire

FILE: rtl/core/irfe_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module irfe_cfg_regs
  import irfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Register write decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENCODING_MODE:     cfg_nxt.mode       = cfg_wdata[1:0];
        REG_PREAMBLE_ON_TIME:  cfg_nxt.pre_on     = cfg_wdata;
        REG_PREAMBLE_OFF_TIME: cfg_nxt.pre_off    = cfg_wdata;
        REG_ONE_TIME:          cfg_nxt.one_time   = cfg_wdata;
        REG_ZERO_TIME:         cfg_nxt.zero_time  = cfg_wdata;
        REG_GAP_TIME:          cfg_nxt.gap_time   = cfg_wdata;
        REG_POSTAMBLE_TIME:    cfg_nxt.post_time  = cfg_wdata;
        REG_FRAME_BITS:        cfg_nxt.frame_bits = cfg_wdata[7:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/core/irfe_frame_planner.sv
`timescale 1ns / 1ps
`default_nettype none

module irfe_frame_planner
  import irfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  cfg_t            cfg,
  input  wire logic [7:0] data_byte,
  input  wire logic       take,
  output plan_t           plan
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] bits_left_r, bits_left_nxt;
  logic [7:0] left;
  logic [7:0] rem;
  logic [3:0] nbits;

  // Bits this byte sends and what is left of the frame after it
  always_comb begin
    left  = in_frame_r ? bits_left_r : cfg.frame_bits;
    nbits = (left >= {4'd0, BITS_PER_BYTE}) ? BITS_PER_BYTE : left[3:0];
    rem   = left - {4'd0, nbits};

    plan.emit  = (cfg.mode != MODE_UNUSED);
    plan.mode  = cfg.mode;
    plan.data  = data_byte;
    plan.pre   = !in_frame_r;
    plan.nbits = nbits;
    plan.post  = (rem == 8'd0);
  end

  // Frame state moves only on bytes that produce segments
  always_comb begin
    in_frame_nxt  = in_frame_r;
    bits_left_nxt = bits_left_r;
    if (take && plan.emit) begin
      in_frame_nxt  = !plan.post;
      bits_left_nxt = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      bits_left_r <= 8'd0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      bits_left_r <= bits_left_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/irfe_seg_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module irfe_seg_sequencer
  import irfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  cfg_t        cfg,
  input  plan_t       plan,
  input  wire logic   in_fire,
  output logic        ready,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic        out_carrier_on,
  output logic [15:0] out_duration,
  output logic        out_last_of_run,
  output logic        out_frame_end
);

  logic        busy_r, busy_nxt;
  plan_t       item_r, item_nxt;
  logic [4:0]  ptr_r, ptr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_on_r, out_on_nxt;
  logic [15:0] out_dur_r, out_dur_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_fend_r, out_fend_nxt;

  logic        advance;
  logic        seg_on;
  logic [15:0] seg_dur;
  logic        seg_last;
  logic [4:0]  nx_ptr;
  logic [4:0]  q;
  logic [4:0]  nq;
  logic [2:0]  bit_k;
  logic        half;
  logic        bit_v;
  logic [15:0] bit_t;
  logic [4:0]  first_ptr;

  assign advance = busy_r && (!out_valid_r || !out_stall);
  assign ready   = !busy_r || (advance && seg_last);

  // Segment at the current slot
  always_comb begin
    q     = ptr_r - SEG_BIT_BASE;
    bit_k = q[3:1];
    half  = q[0];
    bit_v = item_r.data[bit_k];
    bit_t = bit_v ? cfg.one_time : cfg.zero_time;
    if (ptr_r < SEG_BIT_BASE) begin
      seg_on  = (ptr_r == SEG_PRE_ON);
      seg_dur = (ptr_r == SEG_PRE_ON) ? cfg.pre_on : cfg.pre_off;
    end else if (ptr_r < SEG_POST) begin
      case (item_r.mode)
        MODE_PULSE_POSITION: begin
          seg_on  = !half;
          seg_dur = half ? bit_t : cfg.gap_time;
        end
        MODE_PULSE_LENGTH: begin
          seg_on  = !half;
          seg_dur = half ? cfg.gap_time : bit_t;
        end
        MODE_BI_PHASE: begin
          // one: off then on; zero: on then off
          seg_on  = ~(bit_v ^ half);
          seg_dur = bit_t;
        end
        default: begin
          seg_on  = 1'b0;
          seg_dur = 16'd0;
        end
      endcase
    end else begin
      seg_on  = (ptr_r == SEG_POST);
      seg_dur = (ptr_r == SEG_POST) ? cfg.post_time : cfg.gap_time;
    end
  end

  // Next slot, skipping bits past the count and a missing postamble
  always_comb begin
    nx_ptr   = ptr_r + 5'd1;
    nq       = nx_ptr - SEG_BIT_BASE;
    seg_last = 1'b0;
    if (ptr_r == SEG_GAP) begin
      seg_last = 1'b1;
    end else if (nx_ptr >= SEG_BIT_BASE && nx_ptr < SEG_POST && nq[4:1] >= item_r.nbits) begin
      nx_ptr   = SEG_POST;
      seg_last = !item_r.post;
    end else if (nx_ptr == SEG_POST) begin
      seg_last = !item_r.post;
    end
  end

  // First slot of a new byte
  always_comb begin
    if (plan.pre) begin
      first_ptr = SEG_PRE_ON;
    end else if (plan.nbits != 4'd0) begin
      first_ptr = SEG_BIT_BASE;
    end else begin
      first_ptr = SEG_POST;
    end
  end

  // Sequencer and output register
  always_comb begin
    busy_nxt      = busy_r;
    item_nxt      = item_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_on_nxt    = out_on_r;
    out_dur_nxt   = out_dur_r;
    out_last_nxt  = out_last_r;
    out_fend_nxt  = out_fend_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_on_nxt    = seg_on;
      out_dur_nxt   = seg_dur;
      out_last_nxt  = seg_last;
      out_fend_nxt  = (ptr_r == SEG_GAP);
      ptr_nxt       = nx_ptr;
      if (seg_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_fire && plan.emit) begin
      busy_nxt = 1'b1;
      item_nxt = plan;
      ptr_nxt  = first_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ptr_r      <= ptr_nxt;
    out_on_r   <= out_on_nxt;
    out_dur_r  <= out_dur_nxt;
    out_last_r <= out_last_nxt;
    out_fend_r <= out_fend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_carrier_on  = out_on_r;
  assign out_duration    = out_dur_r;
  assign out_last_of_run = out_last_r;
  assign out_frame_end   = out_fend_r;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import irfe_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_PRINTS   = 40;

  // One carrier segment as seen on the out_ channel
  typedef struct packed {
    logic        carrier_on;
    logic [15:0] duration;
    logic        last_of_run;
    logic        frame_end;
  } seg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_carrier_on;
  logic [15:0]           out_duration;
  logic                  out_last_of_run;
  logic                  out_frame_end;

  // Encoder shadow: register copy and frame state
  cfg_t        shadow_cfg = '0;
  logic [7:0]  bits_left = 8'h00;
  logic        frame_open = 1'b0;
  seg_t        pending_segs[$];

  // Traffic shaping knobs
  bit          steady_send = 1'b0;
  bit          quiet_recv = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_encoded = 0;
  int unsigned dropped_bytes = 0;
  int unsigned frames_closed = 0;
  int unsigned segs_checked = 0;
  int unsigned input_held_cycles = 0;
  int unsigned cfg_writes = 0;

  ir_remote_frame_encoder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_carrier_on  (out_carrier_on),
    .out_duration    (out_duration),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

  always #2 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d segments outstanding",
               cycle_count, pending_segs.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void push_seg(input logic on, input logic [15:0] dur, input logic fend);
    seg_t s;
    s.carrier_on  = on;
    s.duration    = dur;
    s.last_of_run = 1'b0;
    s.frame_end   = fend;
    pending_segs.push_back(s);
  endfunction

  // Expected segments for one accepted command byte
  function automatic void encode_byte(input logic [7:0] data);
    logic        b;
    logic [15:0] t;
    seg_t        tail;
    if (shadow_cfg.mode == MODE_UNUSED) begin
      dropped_bytes++;
      return;
    end
    bytes_encoded++;
    // opening byte: preamble and load the bit counter
    if (!frame_open) begin
      frame_open = 1'b1;
      bits_left  = shadow_cfg.frame_bits;
      push_seg(1'b1, shadow_cfg.pre_on, 1'b0);
      push_seg(1'b0, shadow_cfg.pre_off, 1'b0);
    end
    // data bits, LSB first
    for (int i = 0; i < BITS_PER_BYTE && bits_left != 8'h00; i++) begin
      b = data[i];
      t = b ? shadow_cfg.one_time : shadow_cfg.zero_time;
      case (shadow_cfg.mode)
        MODE_PULSE_POSITION: begin
          push_seg(1'b1, shadow_cfg.gap_time, 1'b0);
          push_seg(1'b0, t, 1'b0);
        end
        MODE_PULSE_LENGTH: begin
          push_seg(1'b1, t, 1'b0);
          push_seg(1'b0, shadow_cfg.gap_time, 1'b0);
        end
        default: begin
          // bi-phase: one is off then on, zero is on then off
          push_seg(~b, t, 1'b0);
          push_seg(b, t, 1'b0);
        end
      endcase
      bits_left = bits_left - 8'd1;
    end
    // closing: postamble and gap
    if (bits_left == 8'h00) begin
      push_seg(1'b1, shadow_cfg.post_time, 1'b0);
      push_seg(1'b0, shadow_cfg.gap_time, 1'b1);
      frame_open = 1'b0;
      frames_closed++;
    end
    tail = pending_segs.pop_back();
    tail.last_of_run = 1'b1;
    pending_segs.push_back(tail);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENCODING_MODE:     shadow_cfg.mode = val[1:0];
      REG_PREAMBLE_ON_TIME:  shadow_cfg.pre_on = val;
      REG_PREAMBLE_OFF_TIME: shadow_cfg.pre_off = val;
      REG_ONE_TIME:          shadow_cfg.one_time = val;
      REG_ZERO_TIME:         shadow_cfg.zero_time = val;
      REG_GAP_TIME:          shadow_cfg.gap_time = val;
      REG_POSTAMBLE_TIME:    shadow_cfg.post_time = val;
      REG_FRAME_BITS:        shadow_cfg.frame_bits = val[7:0];
      default: ;
    endcase
  endfunction

  // Bytes needed to finish the open frame, or a whole new one
  function automatic int unsigned bytes_to_close();
    if (frame_open) return (int'(bits_left) + 7) / 8;
    if (shadow_cfg.frame_bits == 8'h00) return 1;
    return (int'(shadow_cfg.frame_bits) + 7) / 8;
  endfunction

  function automatic logic [15:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_frame_bits();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 13) return 8'hFF;
    if (r < 23) return 8'($urandom_range(25, 254));
    return 8'($urandom_range(1, 24));
  endfunction

  // Register write; called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop the request line, wait for all segments, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one byte until accepted; bursts with random gaps unless steady
  task automatic send_byte(input logic [7:0] data);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_byte(data);
    @(negedge clk);
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        in_valid     <= 1'b0;
        in_data_byte <= 8'($urandom);
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic set_times(input logic [15:0] pre_on, input logic [15:0] pre_off,
                           input logic [15:0] one_t, input logic [15:0] zero_t,
                           input logic [15:0] gap_t, input logic [15:0] post_t);
    write_reg(REG_PREAMBLE_ON_TIME, pre_on);
    write_reg(REG_PREAMBLE_OFF_TIME, pre_off);
    write_reg(REG_ONE_TIME, one_t);
    write_reg(REG_ZERO_TIME, zero_t);
    write_reg(REG_GAP_TIME, gap_t);
    write_reg(REG_POSTAMBLE_TIME, post_t);
  endtask

  // Random register settings; mode stays among the defined ones
  task automatic randomize_setup(input bit all_regs);
    logic [CFG_DATA_W-1:0] v;
    if (all_regs || $urandom_range(0, 2) == 0) begin
      v = 16'($urandom);
      v[1:0] = 2'($urandom_range(0, 2));
      write_reg(REG_ENCODING_MODE, v);
    end
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_PREAMBLE_ON_TIME, pick_time());
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_PREAMBLE_OFF_TIME, pick_time());
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_ONE_TIME, pick_time());
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_ZERO_TIME, pick_time());
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_GAP_TIME, pick_time());
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_POSTAMBLE_TIME, pick_time());
    if (all_regs || $urandom_range(0, 1) == 0) begin
      v = 16'($urandom);
      v[7:0] = pick_frame_bits();
      write_reg(REG_FRAME_BITS, v);
    end
  endtask

  // Registers at reset: zero-length frame, all durations zero
  task automatic test_reset_defaults();
    send_byte(8'hA5);
  endtask

  // Every mode with all-zero and all-one bytes over a two-byte frame
  task automatic test_each_mode();
    logic [1:0] modes [3];
    modes = '{MODE_PULSE_POSITION, MODE_PULSE_LENGTH, MODE_BI_PHASE};
    foreach (modes[m]) begin
      settle();
      write_reg(REG_ENCODING_MODE, {14'h0000, modes[m]});
      set_times(16'h1100 + 16'(m), 16'h2200 + 16'(m), 16'h3300 + 16'(m),
                16'h4400 + 16'(m), 16'h5500 + 16'(m), 16'h6600 + 16'(m));
      write_reg(REG_FRAME_BITS, 16'd16);
      send_byte(8'h00);
      send_byte(8'hFF);
    end
  endtask

  // Largest and smallest durations
  task automatic test_extreme_times();
    settle();
    write_reg(REG_ENCODING_MODE, {14'h0000, MODE_BI_PHASE});
    set_times(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_FRAME_BITS, 16'd8);
    send_byte(8'h80);
    settle();
    set_times(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_byte(8'h01);
  endtask

  // Frame length not a multiple of eight
  task automatic test_partial_byte();
    settle();
    write_reg(REG_ENCODING_MODE, {14'h0000, MODE_PULSE_LENGTH});
    set_times(16'd9000, 16'd4500, 16'd1690, 16'd560, 16'd560, 16'd560);
    write_reg(REG_FRAME_BITS, 16'd11);
    send_byte(8'h5A);
    send_byte(8'hFF);
    settle();
    write_reg(REG_FRAME_BITS, 16'd3);
    send_byte(8'hF6);
  endtask

  // Unused mode drops bytes; upper bits of the mode write are masked
  task automatic test_unused_mode();
    settle();
    write_reg(REG_ENCODING_MODE, {14'h0000, MODE_UNUSED});
    send_byte(8'h3C);
    send_byte(8'hC3);
    settle();
    write_reg(REG_ENCODING_MODE, 16'hFFF9);
    write_reg(REG_FRAME_BITS, 16'hAB05);
    send_byte(8'h96);
  endtask

  // Mode and times change between bytes of an open frame; length waits for next frame
  task automatic test_midframe_write();
    settle();
    write_reg(REG_ENCODING_MODE, {14'h0000, MODE_PULSE_LENGTH});
    write_reg(REG_FRAME_BITS, 16'd16);
    send_byte(8'hA5);
    settle();
    write_reg(REG_ENCODING_MODE, {14'h0000, MODE_PULSE_POSITION});
    write_reg(REG_ONE_TIME, 16'h0BEE);
    write_reg(REG_GAP_TIME, 16'h0777);
    write_reg(REG_FRAME_BITS, 16'd4);
    send_byte(8'h3C);
    send_byte(8'h0F);
  endtask

  // Writes past the register list leave everything as it was
  task automatic test_bad_index();
    settle();
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) write_reg(CFG_IDX_W'(i), 16'($urandom));
    send_byte(8'h69);
  endtask

  // Receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    settle();
    randomize_setup(1'b1);
    write_reg(REG_FRAME_BITS, 16'd24);
    steady_send = 1'b1;
    hold_left   = HOLD_CYCLES;
    repeat (8) send_byte(8'($urandom));
    steady_send = 1'b0;
  endtask

  // Random frames with random settings, plus some unused-mode noise
  task automatic test_random_frames();
    int unsigned           target;
    int unsigned           nbytes;
    int unsigned           r;
    bit                    first;
    logic [CFG_DATA_W-1:0] v;
    target = bytes_encoded + RANDOM_ITEMS;
    first  = 1'b1;
    while (bytes_encoded < target) begin
      settle();
      randomize_setup(first);
      first       = 1'b0;
      steady_send = ($urandom_range(0, 5) == 0);
      quiet_recv  = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        v = 16'($urandom);
        v[1:0] = MODE_UNUSED;
        write_reg(REG_ENCODING_MODE, v);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        settle();
        v = 16'($urandom);
        v[1:0] = 2'($urandom_range(0, 2));
        write_reg(REG_ENCODING_MODE, v);
      end
      // mostly whole frames, sometimes cut short or one byte over
      nbytes = bytes_to_close();
      r = $urandom_range(0, 9);
      if (r < 2) nbytes = $urandom_range(1, nbytes);
      else if (r == 2) nbytes++;
      repeat (nbytes) send_byte(8'($urandom));
    end
    steady_send = 1'b0;
    quiet_recv  = 1'b0;
  endtask

  // Receiver stall pattern, with a counted long hold-off on request
  initial begin : recv_pattern
    int unsigned run_len;
    run_len = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet_recv) begin
        out_stall <= 1'b0;
      end else if (run_len > 0) begin
        run_len--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        run_len = $urandom_range(0, 6);
      end
    end
  end

  // Segment checker
  always @(posedge clk) begin : check_seg
    seg_t want;
    if (rst_n) begin
      if (in_valid && in_stall) input_held_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_segs.size() == 0) begin
          flag_error($sformatf("segment on=%0b dur=%0d with none expected",
                               out_carrier_on, out_duration));
        end else begin
          want = pending_segs.pop_front();
          if (out_carrier_on !== want.carrier_on)
            flag_error($sformatf("seg %0d carrier_on got %0b exp %0b",
                                 segs_checked, out_carrier_on, want.carrier_on));
          if (out_duration !== want.duration)
            flag_error($sformatf("seg %0d duration got %0d exp %0d",
                                 segs_checked, out_duration, want.duration));
          if (out_last_of_run !== want.last_of_run)
            flag_error($sformatf("seg %0d last_of_run got %0b exp %0b",
                                 segs_checked, out_last_of_run, want.last_of_run));
          if (out_frame_end !== want.frame_end)
            flag_error($sformatf("seg %0d frame_end got %0b exp %0b",
                                 segs_checked, out_frame_end, want.frame_end));
          segs_checked++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_each_mode();
    test_extreme_times();
    test_partial_byte();
    test_unused_mode();
    test_midframe_write();
    test_bad_index();
    test_backpressure();
    test_random_frames();
    settle();
    $display("Encoded %0d command bytes (%0d dropped in unused mode), %0d frames closed,",
             bytes_encoded, dropped_bytes, frames_closed);
    $display("%0d segments checked, %0d register writes, input stalled %0d cycles.",
             segs_checked, cfg_writes, input_held_cycles);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/irfe_pkg.sv
rtl/core/irfe_cfg_regs.sv
rtl/core/irfe_frame_planner.sv
rtl/core/irfe_seg_sequencer.sv
rtl/core/ir_remote_frame_encoder_unit.sv
tb/tb.sv
